// File: hdl/tlic_pkg.sv
`default_nettype none
package tlic_pkg;
    localparam int L1_INDEX_BITS_MAX_D = 10;
    localparam int L2_INDEX_BITS_MAX_D = 10;
    localparam int L2_WAYS_LOG2_MAX_D  = 3;
    localparam int STAMP_BITS_D        = 32;
    localparam int ADDR_W              = 64;

    localparam logic [1:0] REG_L1_SIZE = 2'd0;
    localparam logic [1:0] REG_L2_SIZE = 2'd1;
    localparam logic [1:0] REG_L2_WAYS = 2'd2;
    localparam logic [1:0] REG_BLOCK   = 2'd3;

    localparam logic MODE_WRITE = 1'b1;

    // Difference of two small values, clamped to zero below and to a maximum above.
    function automatic logic [4:0] sat_sub(input logic [5:0] total, input logic [5:0] sub,
                                           input logic [4:0] maxv);
        logic [5:0] d;
        begin
            d = (total > sub) ? (total - sub) : 6'd0;
            sat_sub = (d > {1'b0, maxv}) ? maxv : d[4:0];
        end
    endfunction
endpackage
`default_nettype wire

// File: hdl/tlic_l2_store.sv
`default_nettype none
module tlic_l2_store import tlic_pkg::*; #(
    parameter int IDX_W   = L2_INDEX_BITS_MAX_D + L2_WAYS_LOG2_MAX_D,
    parameter int STAMP_W = STAMP_BITS_D
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [IDX_W-1:0]   i_waddr,
    input  wire logic [ADDR_W-1:0]  i_wtag,
    input  wire logic               i_wdirty,
    input  wire logic [STAMP_W-1:0] i_wstamp,
    input  wire logic [IDX_W-1:0]   i_raddr,
    output logic [ADDR_W-1:0]       o_rtag,
    output logic                    o_rdirty,
    output logic [STAMP_W-1:0]      o_rstamp
);
    localparam int DEPTH = 1 << IDX_W;
    logic [ADDR_W-1:0]  r_tag   [DEPTH];
    logic               r_dirty [DEPTH];
    logic [STAMP_W-1:0] r_stamp [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_tag[i_waddr]   <= i_wtag;
            r_dirty[i_waddr] <= i_wdirty;
            r_stamp[i_waddr] <= i_wstamp;
        end
        o_rtag   <= r_tag[i_raddr];
        o_rdirty <= r_dirty[i_raddr];
        o_rstamp <= r_stamp[i_raddr];
    end
endmodule
`default_nettype wire

// File: hdl/two_level_inclusive_cache_controller_top.sv
`default_nettype none
// Each accepted access is handled by a sequencer that reads one L2 way per step through a
// single read port, and is then offered as a result.
// One access is in flight at a time; the result waits in an output register and the next
// access is taken at the earliest the cycle after it has been transferred.
// After reset a clearing pass over every L1 line and every L2 slot clears the valid bits and
// stamps; no access is accepted meanwhile.
module two_level_inclusive_cache_controller_top import tlic_pkg::*; #(
    parameter int L1_INDEX_BITS_MAX = L1_INDEX_BITS_MAX_D,
    parameter int L2_INDEX_BITS_MAX = L2_INDEX_BITS_MAX_D,
    parameter int L2_WAYS_LOG2_MAX  = L2_WAYS_LOG2_MAX_D,
    parameter int STAMP_BITS        = STAMP_BITS_D
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [4:0]        i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_mode,
    input  wire logic [ADDR_W-1:0] i_address,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_l1_hit,
    output logic                   o_l2_hit,
    output logic                   o_write_back
);
    localparam int L1N  = L1_INDEX_BITS_MAX;
    localparam int WL   = (L2_WAYS_LOG2_MAX > 0) ? L2_WAYS_LOG2_MAX : 1;
    localparam int L2K  = L2_INDEX_BITS_MAX + L2_WAYS_LOG2_MAX;
    localparam int WAYS = 1 << L2_WAYS_LOG2_MAX;
    localparam int CW   = (L1N > L2K ? L1N : L2K) + 1;
    localparam int CLR_LAST = (1 << (L1N > L2K ? L1N : L2K)) - 1;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_L1RD, S_L1WAIT, S_L1CHK,
        S_HSTAMP_RD, S_HSTAMP_WAIT, S_HSTAMP_CHK,
        S_VDIRTY_RD, S_VDIRTY_WAIT, S_VDIRTY_CHK,
        S_SCAN_RD, S_SCAN_WAIT, S_SCAN_CHK,
        S_VICT_RD, S_VICT_WAIT, S_VICT_CHK, S_L1INV_RD, S_L1INV_WAIT, S_L1INV_CHK,
        S_FILL, S_DONE
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_cnt;
    logic [4:0] r_l1sz, r_l2sz;
    logic [1:0] r_ways;
    logic [3:0] r_blk;
    logic r_wr;
    logic [ADDR_W-1:0] r_blkaddr;
    logic [STAMP_BITS-1:0] r_count;
    logic [WL-1:0] r_way;
    logic r_have_empty;
    logic [WL-1:0] r_empty_way;
    logic [WL-1:0] r_best;
    logic [STAMP_BITS-1:0] r_best_stamp;
    logic r_hit1, r_hit2, r_wb;
    logic [ADDR_W-1:0] r_vaddr;
    logic r_l1dirty_old;

    // Geometry.
    logic [4:0] w_s, w_i1b, w_i2b;
    logic [L2_WAYS_LOG2_MAX:0] w_ways;
    always_comb begin
        w_s = ({3'd0, r_ways} > 5'(L2_WAYS_LOG2_MAX)) ? 5'(L2_WAYS_LOG2_MAX) : {3'd0, r_ways};
        w_i1b = sat_sub({1'b0, r_l1sz}, {2'b0, r_blk}, 5'(L1N));
        w_i2b = sat_sub({1'b0, r_l2sz}, 6'({2'b0, r_blk}) + {1'b0, w_s},
                        5'(L2_INDEX_BITS_MAX));
        w_ways = (L2_WAYS_LOG2_MAX + 1)'(1) << w_s;
    end

    logic [ADDR_W-1:0] w_mask1, w_mask2;
    assign w_mask1 = ~({ADDR_W{1'b1}} << w_i1b);
    assign w_mask2 = ~({ADDR_W{1'b1}} << w_i2b);

    logic [L1N-1:0] w_idx1;
    logic [ADDR_W-1:0] w_tag1, w_tag2;
    logic [L2_INDEX_BITS_MAX-1:0] w_idx2, w_vset;
    logic [ADDR_W-1:0] w_vtag;
    assign w_idx1 = L1N'(r_blkaddr & w_mask1);
    assign w_tag1 = r_blkaddr >> w_i1b;
    assign w_idx2 = L2_INDEX_BITS_MAX'(r_blkaddr & w_mask2);
    assign w_tag2 = r_blkaddr >> w_i2b;
    assign w_vset = L2_INDEX_BITS_MAX'(r_vaddr & w_mask2);
    assign w_vtag = r_vaddr >> w_i2b;

    // L1 store, with valid bits and dirty bits cleared by the sweep.
    localparam int L1D = 1 << L1N;
    logic [ADDR_W-1:0] r_l1_tag [L1D];
    logic r_l1_valid [L1D];
    logic r_l1_dirty [L1D];
    logic [L1N-1:0] r_l1_raddr;
    logic [ADDR_W-1:0] r_l1_rtag;
    logic r_l1_rvalid, r_l1_rdirty;
    logic w_l1_we;
    logic [L1N-1:0] w_l1_waddr;
    logic [ADDR_W-1:0] w_l1_wtag;
    logic w_l1_wvalid, w_l1_wdirty;

    always_ff @(posedge i_clk) begin
        if (w_l1_we) begin
            r_l1_tag[w_l1_waddr]   <= w_l1_wtag;
            r_l1_valid[w_l1_waddr] <= w_l1_wvalid;
            r_l1_dirty[w_l1_waddr] <= w_l1_wdirty;
        end
        r_l1_rtag   <= r_l1_tag[r_l1_raddr];
        r_l1_rvalid <= r_l1_valid[r_l1_raddr];
        r_l1_rdirty <= r_l1_dirty[r_l1_raddr];
    end

    // L2 store: valid bits kept in their own memory.
    localparam int L2D = 1 << L2K;
    logic r_l2_valid [L2D];
    logic r_l2_rvalid;
    logic [L2K-1:0] r_l2_raddr;
    logic w_l2_we;
    logic [L2K-1:0] w_l2_waddr;
    logic [ADDR_W-1:0] w_l2_wtag;
    logic w_l2_wvalid, w_l2_wdirty;
    logic [STAMP_BITS-1:0] w_l2_wstamp;
    logic [ADDR_W-1:0] w_l2_rtag;
    logic w_l2_rdirty;
    logic [STAMP_BITS-1:0] w_l2_rstamp;

    always_ff @(posedge i_clk) begin
        if (w_l2_we) r_l2_valid[w_l2_waddr] <= w_l2_wvalid;
        r_l2_rvalid <= r_l2_valid[r_l2_raddr];
    end

    tlic_l2_store #(.IDX_W(L2K), .STAMP_W(STAMP_BITS)) u_l2 (
        .i_clk(i_clk), .i_we(w_l2_we), .i_waddr(w_l2_waddr), .i_wtag(w_l2_wtag),
        .i_wdirty(w_l2_wdirty), .i_wstamp(w_l2_wstamp), .i_raddr(r_l2_raddr),
        .o_rtag(w_l2_rtag), .o_rdirty(w_l2_rdirty), .o_rstamp(w_l2_rstamp)
    );

    function automatic logic [L2K-1:0] slot(input logic [L2_INDEX_BITS_MAX-1:0] set,
                                            input logic [WL-1:0] way);
        logic [L2K:0] t;
        begin
            t = ((L2K + 1)'(set) << L2_WAYS_LOG2_MAX) | (L2K + 1)'(way);
            slot = t[L2K-1:0];
        end
    endfunction

    logic [WL-1:0] w_fill_way;
    assign w_fill_way = r_have_empty ? r_empty_way : r_best;
    logic w_l2_match, w_vmatch, w_last_way;
    assign w_l2_match = r_l2_rvalid && (w_l2_rtag == w_tag2);
    assign w_vmatch   = r_l2_rvalid && (w_l2_rtag == w_vtag);
    assign w_last_way = ((L2_WAYS_LOG2_MAX + 1)'(r_way) + 1'b1) == w_ways;

    // Write-port muxing for both stores.
    logic [ADDR_W-1:0] w_l2_evict_addr;
    assign w_l2_evict_addr = (w_l2_rtag << w_i2b) | ADDR_W'(w_idx2);

    always_comb begin
        w_l1_we = 1'b0; w_l1_waddr = w_idx1; w_l1_wtag = w_tag1;
        w_l1_wvalid = 1'b1; w_l1_wdirty = 1'b0;
        w_l2_we = 1'b0; w_l2_waddr = slot(w_idx2, r_way); w_l2_wtag = w_l2_rtag;
        w_l2_wvalid = 1'b1; w_l2_wdirty = w_l2_rdirty; w_l2_wstamp = w_l2_rstamp;
        case (r_state)
            S_CLEAR: begin
                w_l1_we = (r_cnt < CW'(L1D));
                w_l1_waddr = r_cnt[L1N-1:0];
                w_l1_wtag = '0; w_l1_wvalid = 1'b0;
                w_l2_we = 1'b1;
                w_l2_waddr = r_cnt[L2K-1:0];
                w_l2_wtag = '0; w_l2_wvalid = 1'b0; w_l2_wdirty = 1'b0; w_l2_wstamp = '0;
            end
            S_HSTAMP_CHK: begin
                w_l2_we = w_l2_match;
                w_l2_wstamp = r_count;
            end
            S_VDIRTY_CHK: begin
                w_l2_we = w_vmatch;
                w_l2_waddr = slot(w_vset, r_way);
                w_l2_wdirty = 1'b1;
            end
            S_SCAN_CHK: begin
                w_l2_we = w_l2_match;
                w_l2_wstamp = r_count;
                w_l2_wdirty = w_l2_rdirty | (r_wr == MODE_WRITE);
            end
            S_L1INV_CHK: begin
                w_l1_we = (r_l1_rtag == (r_vaddr >> w_i1b));
                w_l1_waddr = L1N'(r_vaddr & w_mask1);
                w_l1_wtag = r_l1_rtag; w_l1_wvalid = 1'b0;
            end
            S_FILL: begin
                w_l2_we = 1'b1;
                w_l2_waddr = slot(w_idx2, w_fill_way);
                w_l2_wtag = w_tag2;
                w_l2_wdirty = (r_wr == MODE_WRITE);
                w_l2_wstamp = r_count;
            end
            S_DONE: begin
                w_l1_we = 1'b1;
                w_l1_wdirty = r_hit1 ? (r_l1dirty_old | (r_wr == MODE_WRITE)) : 1'b0;
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE) && !o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt <= '0;
            r_l1sz <= 5'd12; r_l2sz <= 5'd15; r_ways <= 2'd3; r_blk <= 4'd5;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_L1_SIZE: r_l1sz <= i_cfg_data;
                    REG_L2_SIZE: r_l2sz <= i_cfg_data;
                    REG_L2_WAYS: r_ways <= i_cfg_data[1:0];
                    REG_BLOCK:   r_blk  <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(CLR_LAST))
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_wr <= i_mode;
                        r_blkaddr <= i_address >> r_blk;
                        r_count <= r_count + 1'b1;
                        r_state <= S_L1RD;
                    end
                end
                S_L1RD: begin
                    r_l1_raddr <= w_idx1;
                    r_hit1 <= 1'b0; r_hit2 <= 1'b0; r_wb <= 1'b0;
                    r_have_empty <= 1'b0; r_empty_way <= '0; r_best <= '0;
                    r_way <= '0;
                    r_state <= S_L1WAIT;
                end
                S_L1WAIT: r_state <= S_L1CHK;
                S_L1CHK: begin
                    r_l1dirty_old <= r_l1_rdirty;
                    r_vaddr <= (r_l1_rtag << w_i1b) | ADDR_W'(w_idx1);
                    if (r_l1_rvalid && r_l1_rtag == w_tag1) begin
                        r_hit1 <= 1'b1;
                        r_state <= S_HSTAMP_RD;
                    end else if (r_l1_rdirty) begin
                        r_state <= S_VDIRTY_RD;
                    end else begin
                        r_state <= S_SCAN_RD;
                    end
                end
                S_HSTAMP_RD: begin
                    r_l2_raddr <= slot(w_idx2, r_way);
                    r_state <= S_HSTAMP_WAIT;
                end
                S_HSTAMP_WAIT: r_state <= S_HSTAMP_CHK;
                S_HSTAMP_CHK: begin
                    r_way <= r_way + 1'b1;
                    r_state <= w_last_way ? S_DONE : S_HSTAMP_RD;
                end
                S_VDIRTY_RD: begin
                    r_l2_raddr <= slot(w_vset, r_way);
                    r_state <= S_VDIRTY_WAIT;
                end
                S_VDIRTY_WAIT: r_state <= S_VDIRTY_CHK;
                S_VDIRTY_CHK: begin
                    if (w_last_way) begin
                        r_way <= '0;
                        r_state <= S_SCAN_RD;
                    end else begin
                        r_way <= r_way + 1'b1;
                        r_state <= S_VDIRTY_RD;
                    end
                end
                S_SCAN_RD: begin
                    r_l2_raddr <= slot(w_idx2, r_way);
                    r_state <= S_SCAN_WAIT;
                end
                S_SCAN_WAIT: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    if (!r_l2_rvalid && !r_have_empty) begin
                        r_have_empty <= 1'b1;
                        r_empty_way <= r_way;
                    end
                    if (r_way == '0 || r_best_stamp > w_l2_rstamp) begin
                        r_best_stamp <= w_l2_rstamp;
                        r_best <= r_way;
                    end
                    if (w_l2_match) begin
                        r_hit2 <= 1'b1;
                        r_state <= S_DONE;
                    end else if (w_last_way) begin
                        r_state <= (r_have_empty || !r_l2_rvalid) ? S_FILL : S_VICT_RD;
                    end else begin
                        r_way <= r_way + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_VICT_RD: begin
                    r_l2_raddr <= slot(w_idx2, r_best);
                    r_state <= S_VICT_WAIT;
                end
                S_VICT_WAIT: r_state <= S_VICT_CHK;
                S_VICT_CHK: begin
                    r_wb <= w_l2_rdirty;
                    r_vaddr <= w_l2_evict_addr;
                    r_state <= S_L1INV_RD;
                end
                S_L1INV_RD: begin
                    r_l1_raddr <= L1N'(r_vaddr & w_mask1);
                    r_state <= S_L1INV_WAIT;
                end
                S_L1INV_WAIT: r_state <= S_L1INV_CHK;
                S_L1INV_CHK: r_state <= S_FILL;
                S_FILL: r_state <= S_DONE;
                S_DONE: begin
                    o_valid <= 1'b1;
                    o_l1_hit <= r_hit1;
                    o_l2_hit <= r_hit2;
                    o_write_back <= r_wb;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import tlic_pkg::*;

    localparam int L1_LINES    = 1 << L1_INDEX_BITS_MAX_D;
    localparam int L2_SLOTS    = 1 << (L2_INDEX_BITS_MAX_D + L2_WAYS_LOG2_MAX_D);
    localparam int STALL_LIMIT = 50000;

    typedef struct packed {
        logic l1_hit;
        logic l2_hit;
        logic write_back;
    } t_access_outcome;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_index;
    logic [4:0]        i_cfg_data;
    logic              i_valid;
    logic              o_ready;
    logic              i_mode;
    logic [ADDR_W-1:0] i_address;
    logic              o_valid;
    logic              i_ready;
    logic              o_l1_hit;
    logic              o_l2_hit;
    logic              o_write_back;

    two_level_inclusive_cache_controller_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_mode(i_mode), .i_address(i_address),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_l1_hit(o_l1_hit), .o_l2_hit(o_l2_hit), .o_write_back(o_write_back)
    );

    // Shadow copy of the cache metadata and geometry.
    logic [4:0]  geo_l1_log2;
    logic [4:0]  geo_l2_log2;
    logic [1:0]  geo_ways_log2;
    logic [3:0]  geo_block_log2;
    logic [63:0] sh_l1_tag [L1_LINES];
    bit          sh_l1_valid [L1_LINES];
    bit          sh_l1_dirty [L1_LINES];
    logic [63:0] sh_l2_tag [L2_SLOTS];
    bit          sh_l2_valid [L2_SLOTS];
    bit          sh_l2_dirty [L2_SLOTS];
    logic [31:0] sh_l2_stamp [L2_SLOTS];
    logic [31:0] sh_access_count;

    t_access_outcome pending_outcomes[$];
    int  error_count;
    int  accesses_sent;
    int  outcomes_checked;
    int  l1_hits_seen;
    int  l2_hits_seen;
    int  write_backs_seen;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  quiet_cycles;
    logic [63:0] regions [4];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int clamp_width(int total, int sub, int maxv);
        int d;
        d = (total > sub) ? total - sub : 0;
        return (d > maxv) ? maxv : d;
    endfunction

    function automatic logic [63:0] low_bits(int n);
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic int l2_slot(logic [63:0] set, int way);
        return int'(((set & (L2_SLOTS / 8 - 1)) << 3) | (way & 7));
    endfunction

    task automatic reset_shadow();
        geo_l1_log2 = 5'd12;
        geo_l2_log2 = 5'd15;
        geo_ways_log2 = 2'd3;
        geo_block_log2 = 4'd5;
        for (int k = 0; k < L1_LINES; k++) begin
            sh_l1_tag[k] = '0;
            sh_l1_valid[k] = 0;
            sh_l1_dirty[k] = 0;
        end
        for (int k = 0; k < L2_SLOTS; k++) begin
            sh_l2_tag[k] = '0;
            sh_l2_valid[k] = 0;
            sh_l2_dirty[k] = 0;
            sh_l2_stamp[k] = '0;
        end
        sh_access_count = '0;
    endtask

    function automatic t_access_outcome predict_access(logic wr, logic [63:0] addr);
        t_access_outcome r;
        int b, s, ways, i1b, i2b, empty_way, hit_way, best, fill;
        bit have_empty;
        logic [63:0] blk, idx1, tag1, idx2, tag2, rb, vset, vtag, etag, eidx;
        logic [31:0] best_stamp;
        r = '0;
        b = geo_block_log2;
        s = (geo_ways_log2 > L2_WAYS_LOG2_MAX_D) ? L2_WAYS_LOG2_MAX_D : geo_ways_log2;
        ways = 1 << s;
        i1b = clamp_width(geo_l1_log2, b, L1_INDEX_BITS_MAX_D);
        i2b = clamp_width(geo_l2_log2, b + s, L2_INDEX_BITS_MAX_D);
        blk = addr >> b;
        idx1 = blk & low_bits(i1b);
        tag1 = blk >> i1b;
        idx2 = blk & low_bits(i2b);
        tag2 = blk >> i2b;
        have_empty = 0;
        empty_way = 0;
        hit_way = 0;
        sh_access_count = sh_access_count + 32'd1;
        if (sh_l1_valid[idx1] && sh_l1_tag[idx1] == tag1) begin
            r.l1_hit = 1'b1;
            for (int w = 0; w < ways; w++)
                if (sh_l2_valid[l2_slot(idx2, w)] && sh_l2_tag[l2_slot(idx2, w)] == tag2)
                    sh_l2_stamp[l2_slot(idx2, w)] = sh_access_count;
            if (wr) sh_l1_dirty[idx1] = 1;
        end else begin
            if (sh_l1_dirty[idx1]) begin
                rb = (sh_l1_tag[idx1] << i1b) | idx1;
                vset = rb & low_bits(i2b);
                vtag = rb >> i2b;
                for (int w = 0; w < ways; w++)
                    if (sh_l2_valid[l2_slot(vset, w)] && sh_l2_tag[l2_slot(vset, w)] == vtag)
                        sh_l2_dirty[l2_slot(vset, w)] = 1;
            end
            sh_l1_dirty[idx1] = 0;
            for (int w = 0; w < ways; w++) begin
                if (!sh_l2_valid[l2_slot(idx2, w)]) begin
                    if (!have_empty) empty_way = w;
                    have_empty = 1;
                end
                if (sh_l2_valid[l2_slot(idx2, w)] && sh_l2_tag[l2_slot(idx2, w)] == tag2) begin
                    r.l2_hit = 1'b1;
                    hit_way = w;
                    sh_l2_stamp[l2_slot(idx2, w)] = sh_access_count;
                    break;
                end
            end
            if (r.l2_hit) begin
                if (wr) sh_l2_dirty[l2_slot(idx2, hit_way)] = 1;
            end else begin
                if (have_empty) begin
                    fill = l2_slot(idx2, empty_way);
                end else begin
                    best = 0;
                    best_stamp = sh_l2_stamp[l2_slot(idx2, 0)];
                    for (int w = 0; w < ways; w++)
                        if (best_stamp > sh_l2_stamp[l2_slot(idx2, w)]) begin
                            best_stamp = sh_l2_stamp[l2_slot(idx2, w)];
                            best = w;
                        end
                    fill = l2_slot(idx2, best);
                    if (sh_l2_dirty[fill]) r.write_back = 1'b1;
                    rb = (sh_l2_tag[fill] << i2b) | idx2;
                    etag = rb >> i1b;
                    eidx = rb & low_bits(i1b);
                    if (sh_l1_tag[eidx] == etag) begin
                        sh_l1_valid[eidx] = 0;
                        sh_l1_dirty[eidx] = 0;
                    end
                end
                sh_l2_tag[fill] = tag2;
                sh_l2_valid[fill] = 1;
                sh_l2_dirty[fill] = wr;
                sh_l2_stamp[fill] = sh_access_count;
            end
        end
        sh_l1_valid[idx1] = 1;
        sh_l1_tag[idx1] = tag1;
        return r;
    endfunction

    task automatic send_access(logic wr, logic [63:0] addr);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_mode = wr;
        i_address = addr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_outcomes.push_back(predict_access(wr, addr));
        accesses_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_L1_SIZE: geo_l1_log2 = value;
            REG_L2_SIZE: geo_l2_log2 = value;
            REG_L2_WAYS: geo_ways_log2 = value[1:0];
            default: geo_block_log2 = value[3:0];
        endcase
    endtask

    task automatic set_geometry(int l1, int l2, int ways, int blk);
        drain();
        write_reg(REG_L1_SIZE, 5'(l1));
        write_reg(REG_L2_SIZE, 5'(l2));
        write_reg(REG_L2_WAYS, 5'(ways));
        write_reg(REG_BLOCK, 5'(blk));
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
    endtask

    // Most addresses fall in a few small regions so that lines are reused and sets fill.
    function automatic logic [63:0] pick_address();
        int b;
        logic [63:0] off;
        b = geo_block_log2;
        if ($urandom_range(19) == 0) return {$urandom, $urandom};
        off = 64'($urandom_range(63)) << b;
        return regions[$urandom_range(3)] + off + (64'($urandom) & low_bits(b));
    endfunction

    task automatic test_directed_hits_and_evictions();
        set_idling(0);
        send_access(1'b0, 64'd0);
        send_access(1'b0, 64'd0);
        send_access(MODE_WRITE, 64'd4);
        send_access(1'b0, 64'h1000);
        for (int k = 2; k < 11; k++) send_access(1'b0, 64'(k) << 12);
        send_access(1'b0, 64'd0);
        send_access(MODE_WRITE, '1);
        send_access(1'b0, '1);
        send_access(MODE_WRITE, 64'h8000_0000_0000_0000);
        send_access(1'b0, 64'h5555_5555_5555_5555);
        send_access(MODE_WRITE, 64'hAAAA_AAAA_AAAA_AAAA);
        send_access(1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
        drain();
    endtask

    task automatic test_random_geometry(int phase, int l1, int l2, int ways, int blk, int n);
        set_geometry(l1, l2, ways, blk);
        for (int k = 0; k < 4; k++) regions[k] = {$urandom, $urandom};
        for (int k = 0; k < n; k++) begin
            if (k % 60 == 0) set_idling(phase + k / 60);
            send_access($urandom_range(1), pick_address());
        end
        drain();
    endtask

    always @(negedge i_clk) begin
        i_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_access_outcome want;
        if (o_valid && i_ready && i_rst_n) begin
            if (pending_outcomes.size() == 0) begin
                $error("result transfer with no access outstanding");
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                outcomes_checked++;
                l1_hits_seen += o_l1_hit;
                l2_hits_seen += o_l2_hit;
                write_backs_seen += o_write_back;
                if (o_l1_hit !== want.l1_hit) begin
                    $error("l1_hit: expected %0b, got %0b", want.l1_hit, o_l1_hit);
                    error_count++;
                end
                if (o_l2_hit !== want.l2_hit) begin
                    $error("l2_hit: expected %0b, got %0b", want.l2_hit, o_l2_hit);
                    error_count++;
                end
                if (o_write_back !== want.write_back) begin
                    $error("write_back: expected %0b, got %0b", want.write_back, o_write_back);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_mode = 1'b0;
        i_address = '0;
        i_ready = 1'b0;
        quiet_cycles = 0;
        error_count = 0;
        accesses_sent = 0;
        outcomes_checked = 0;
        l1_hits_seen = 0;
        l2_hits_seen = 0;
        write_backs_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        reset_shadow();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_hits_and_evictions();
        test_random_geometry(0, 12, 15, 3, 5, 240);
        test_random_geometry(1, 1, 1, 0, 0, 180);
        test_random_geometry(2, 22, 25, 3, 12, 200);
        test_random_geometry(3, 31, 31, 3, 15, 150);
        test_random_geometry(0, 8, 10, 1, 2, 240);
        test_random_geometry(1, 10, 12, 2, 4, 240);
        test_random_geometry(2, 6, 9, 0, 3, 240);
        drain();
        repeat (50) @(posedge i_clk);

        $display("Checked %0d of %0d accesses over seven cache geometries and four idling mixes.",
                 outcomes_checked, accesses_sent);
        $display("Seen: %0d L1 hits, %0d L2 hits, %0d dirty write-backs.",
                 l1_hits_seen, l2_hits_seen, write_backs_seen);
        if (error_count == 0 && pending_outcomes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: two_level_inclusive_cache_controller_top.f
hdl/tlic_pkg.sv
hdl/tlic_l2_store.sv
hdl/two_level_inclusive_cache_controller_top.sv
verif/tb.sv
